// ===== sv/doc_pkg.sv =====
// Shared types, codes and saturation tables for the dissolved oxygen converter.
package doc_pkg;

  // Calibration status codes
  localparam logic [1:0] CAL_NONE     = 2'd0;
  localparam logic [1:0] CAL_PARTIAL  = 2'd1;
  localparam logic [1:0] CAL_COMPLETE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ZERO_VOLTAGE     = 3'd0;
  localparam logic [2:0] REG_SAT_VOLTAGE_LOW  = 3'd1;
  localparam logic [2:0] REG_SAT_VOLTAGE_HIGH = 3'd2;
  localparam logic [2:0] REG_SAT_TEMP_LOW     = 3'd3;
  localparam logic [2:0] REG_SAT_TEMP_HIGH    = 3'd4;

  // Temperature window and limits
  localparam logic signed [14:0] TEMP_LO   = 15'sd1500;
  localparam logic signed [14:0] TEMP_HI   = 15'sd4000;
  localparam logic [8:0]         SPAN_MIN  = 9'd500;
  localparam int                 SAT_ROWS  = 26;
  localparam logic [16:0]        ROUGH_DEN = 17'd100000;
  localparam logic [15:0]        ROUGH_HALF = 16'd50000;
  localparam logic [12:0]        DIV100_MUL = 13'd5243;  // x/100 as (x*5243)>>19, x <= 2500
  localparam int                 QBITS     = 10;

  // Saturation in 0.01 mg/L, one row per whole degree from 15 C
  localparam logic [9:0] SAT_TABLE [SAT_ROWS] = '{
    10'd1008, 10'd986, 10'd966, 10'd947, 10'd928, 10'd909, 10'd891, 10'd873, 10'd856,
    10'd838, 10'd822, 10'd807, 10'd792, 10'd777, 10'd763, 10'd749, 10'd736, 10'd723,
    10'd710, 10'd698, 10'd686, 10'd675, 10'd664, 10'd653, 10'd643, 10'd633
  };

  // Saturation rounded half up to 0.1 mg/L, the cap on a calibrated result
  localparam logic [6:0] CAP_TABLE [SAT_ROWS] = '{
    7'd101, 7'd99, 7'd97, 7'd95, 7'd93, 7'd91, 7'd89, 7'd87, 7'd86,
    7'd84, 7'd82, 7'd81, 7'd79, 7'd78, 7'd76, 7'd75, 7'd74, 7'd72,
    7'd71, 7'd70, 7'd69, 7'd68, 7'd66, 7'd65, 7'd64, 7'd63
  };

  // Side information that travels with an item through the divider
  typedef struct packed {
    logic       clamped;
    logic       err;
    logic [1:0] status;
    logic       zero_res;
    logic [6:0] cap;
  } meta_t;

endpackage

// ===== sv/dissolved_oxygen_converter.sv =====
// Dissolved oxygen converter: clamped temperature lookup, two-point calibration, pipelined divide.
// Takes one probe voltage / temperature beat per cycle unless the output is held, and returns one
// result beat per input beat, in order, through sixteen register stages (five arithmetic stages,
// ten restoring divider stages producing one quotient bit each, and the output register). The whole
// pipeline holds
// when a result waits on out_tready, so in_tready follows out_tready while the output register
// is full. Calibration registers are written through the cfg_ port, always ready, and must only
// change while no beat is in flight. Registers: 0 zero_voltage, 1 sat_voltage_low,
// 2 sat_voltage_high, 3 sat_temp_low, 4 sat_temp_high; other indexes are ignored.
module dissolved_oxygen_converter
  import doc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] probe_voltage, [30:16] water_temp, [31] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] oxygen_tenths, [10] temp_clamped,
                                  // [11] span_error, [13:12] calib_status, [15:14] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_LIMIT = (TABLE_ENTRIES < SAT_ROWS) ? TABLE_ENTRIES - 1 : SAT_ROWS - 1;
  localparam logic [4:0] IDX_MAX = IDX_LIMIT[4:0];

  // ---------------------------------------------------------------- configuration
  logic [15:0] zero_v_r, sat_vl_r, sat_vh_r;
  logic [11:0] sat_tl_r, sat_th_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_v_r <= '0;
      sat_vl_r <= '0;
      sat_vh_r <= '0;
      sat_tl_r <= 12'd2500;
      sat_th_r <= 12'd2500;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_VOLTAGE:     zero_v_r <= cfg_data;
        REG_SAT_VOLTAGE_LOW:  sat_vl_r <= cfg_data;
        REG_SAT_VOLTAGE_HIGH: sat_vh_r <= cfg_data;
        REG_SAT_TEMP_LOW:     sat_tl_r <= cfg_data[11:0];
        REG_SAT_TEMP_HIGH:    sat_th_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic out_vld_r;
  logic adv;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------- stage 1: clamp, index, region
  logic signed [14:0] t_in;
  logic        [11:0] tc;
  logic               clamp_c;
  logic        [24:0] idx_prod;
  logic        [4:0]  idx_c;
  logic        [1:0]  status_c;
  logic        [11:0] d_c, frac_c;
  logic signed [16:0] base_c, dv_c;
  logic        [15:0] v_c;

  assign t_in = $signed(in_tdata[30:16]);
  assign v_c  = in_tdata[15:0];

  always_comb begin
    // clamp temperature to the table window
    if (t_in < TEMP_LO) begin
      tc      = TEMP_LO[11:0];
      clamp_c = 1'b1;
    end else if (t_in > TEMP_HI) begin
      tc      = TEMP_HI[11:0];
      clamp_c = 1'b1;
    end else begin
      tc      = t_in[11:0];
      clamp_c = 1'b0;
    end
    // whole degrees above 15 C
    idx_prod = 25'(tc - TEMP_LO[11:0]) * 25'(DIV100_MUL);
    idx_c    = idx_prod[23:19];
    if (idx_c > IDX_MAX) idx_c = IDX_MAX;
    // calibration status
    if (zero_v_r == '0)                      status_c = CAL_NONE;
    else if (sat_vl_r != '0 && sat_vh_r != '0) status_c = CAL_COMPLETE;
    else if (sat_vl_r != '0 || sat_vh_r != '0) status_c = CAL_PARTIAL;
    else                                     status_c = CAL_NONE;
    // interpolation region
    dv_c   = $signed({1'b0, sat_vh_r}) - $signed({1'b0, sat_vl_r});
    d_c    = 12'd1;
    frac_c = '0;
    if (tc <= sat_tl_r) begin
      base_c = $signed({1'b0, sat_vl_r}) - $signed({1'b0, zero_v_r});
    end else if (tc >= sat_th_r) begin
      base_c = $signed({1'b0, sat_vh_r}) - $signed({1'b0, zero_v_r});
    end else begin
      base_c = $signed({1'b0, sat_vl_r}) - $signed({1'b0, zero_v_r});
      d_c    = sat_th_r - sat_tl_r;
      frac_c = tc - sat_tl_r;
    end
  end

  logic               s1_vld_r, s1_clamp_r, s1_vpos_r;
  logic        [4:0]  s1_idx_r;
  logic        [1:0]  s1_status_r;
  logic        [11:0] s1_d_r, s1_frac_r;
  logic signed [16:0] s1_base_r, s1_dv_r;
  logic        [15:0] s1_v_r, s1_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clamp_r  <= clamp_c;
      s1_idx_r    <= idx_c;
      s1_status_r <= status_c;
      s1_d_r      <= d_c;
      s1_frac_r   <= frac_c;
      s1_base_r   <= base_c;
      s1_dv_r     <= dv_c;
      s1_v_r      <= v_c;
      s1_vpos_r   <= v_c > zero_v_r;
      s1_vz_r     <= v_c - zero_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 2: table, span
  logic signed [29:0] sp_a, sp_b;
  logic signed [31:0] span_c;

  assign sp_a   = s1_base_r * $signed({1'b0, s1_d_r});
  assign sp_b   = $signed({1'b0, s1_frac_r}) * s1_dv_r;
  assign span_c = 32'(sp_a) + 32'(sp_b);

  logic               s2_vld_r, s2_clamp_r, s2_vpos_r;
  logic        [1:0]  s2_status_r;
  logic        [9:0]  s2_sat_r;
  logic        [6:0]  s2_cap_r;
  logic        [11:0] s2_d_r;
  logic signed [31:0] s2_span_r;
  logic        [15:0] s2_v_r, s2_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_clamp_r  <= s1_clamp_r;
      s2_vpos_r   <= s1_vpos_r;
      s2_status_r <= s1_status_r;
      s2_sat_r    <= SAT_TABLE[s1_idx_r];
      s2_cap_r    <= CAP_TABLE[s1_idx_r];
      s2_d_r      <= s1_d_r;
      s2_span_r   <= span_c;
      s2_v_r      <= s1_v_r;
      s2_vz_r     <= s1_vz_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: span check, first product
  logic        complete_c2, err_c;
  logic [20:0] span_min_c;
  logic [15:0] mv_c;
  logic [32:0] den_c;

  assign complete_c2 = s2_status_r == CAL_COMPLETE;
  assign span_min_c  = 21'(s2_d_r) * 21'(SPAN_MIN);
  assign err_c       = complete_c2 && (s2_span_r < $signed({11'b0, span_min_c}));
  assign mv_c        = complete_c2 ? s2_vz_r : s2_v_r;
  // span * 20, used as 2*den
  assign den_c       = 33'({s2_span_r[27:0], 4'b0}) + 33'({s2_span_r[27:0], 2'b0});

  logic        s3_vld_r, s3_complete_r;
  meta_t       s3_meta_r;
  logic [25:0] s3_m1_r;
  logic [11:0] s3_d_r;
  logic [32:0] s3_den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_complete_r      <= complete_c2;
      s3_meta_r.clamped  <= s2_clamp_r;
      s3_meta_r.err      <= err_c;
      s3_meta_r.status   <= s2_status_r;
      s3_meta_r.zero_res <= complete_c2 && (err_c || !s2_vpos_r);
      s3_meta_r.cap      <= s2_cap_r;
      s3_m1_r            <= 26'(s2_sat_r) * 26'(mv_c);
      s3_d_r             <= s2_d_r;
      s3_den2_r          <= den_c;
    end
  end

  // ---------------------------------------------------------------- stage 4: dividend, divisor
  logic [37:0] num_c;
  logic [39:0] n_c;
  logic [32:0] dv_div_c;

  assign num_c = 38'(s3_m1_r) * 38'(s3_d_r);

  always_comb begin
    if (s3_complete_r) begin
      // (2*num + den) / (2*den) with den = 10*span
      n_c      = {1'b0, num_c, 1'b0} + 40'(s3_den2_r[32:1]);
      dv_div_c = s3_den2_r;
    end else begin
      n_c      = 40'(s3_m1_r) + 40'(ROUGH_HALF);
      dv_div_c = 33'(ROUGH_DEN);
    end
  end

  logic        s4_vld_r;
  meta_t       s4_meta_r;
  logic [39:0] s4_n_r;
  logic [32:0] s4_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_meta_r <= s3_meta_r;
      s4_n_r    <= n_c;
      s4_dv_r   <= dv_div_c;
    end
  end

  // ---------------------------------------------------------------- stage 5: overflow check
  logic        dq_vld_r  [QBITS+1];
  meta_t       dq_meta_r [QBITS+1];
  logic [39:0] dq_rem_r  [QBITS+1];
  logic [32:0] dq_dv_r   [QBITS+1];
  logic        dq_ovf_r  [QBITS+1];
  logic [QBITS-1:0] dq_q_r [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dq_vld_r[0] <= 1'b0;
    else if (adv) dq_vld_r[0] <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq_meta_r[0] <= s4_meta_r;
      dq_rem_r[0]  <= s4_n_r;
      dq_dv_r[0]   <= s4_dv_r;
      dq_ovf_r[0]  <= {3'b0, s4_n_r} >= {s4_dv_r, {QBITS{1'b0}}};
      dq_q_r[0]    <= '0;
    end
  end

  // ---------------------------------------------------------------- restoring divider, one bit a stage
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int B = QBITS - 1 - k;
    logic [42:0] shd_c;
    logic        ge_c;

    assign shd_c = 43'(dq_dv_r[k]) << B;
    assign ge_c  = {3'b0, dq_rem_r[k]} >= shd_c;

    always_ff @(posedge clk) begin
      if (!rst_n) dq_vld_r[k+1] <= 1'b0;
      else if (adv) dq_vld_r[k+1] <= dq_vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dq_meta_r[k+1] <= dq_meta_r[k];
        dq_dv_r[k+1]   <= dq_dv_r[k];
        dq_ovf_r[k+1]  <= dq_ovf_r[k];
        dq_rem_r[k+1]  <= ge_c ? 40'({3'b0, dq_rem_r[k]} - shd_c) : dq_rem_r[k];
        dq_q_r[k+1]    <= dq_q_r[k] | (QBITS'(ge_c) << B);
      end
    end
  end

  // ---------------------------------------------------------------- output register
  meta_t       fin_meta;
  logic [9:0]  res_c;

  assign fin_meta = dq_meta_r[QBITS];

  always_comb begin
    // saturate, then cap a calibrated result at the table saturation
    res_c = dq_ovf_r[QBITS] ? 10'd1023 : dq_q_r[QBITS];
    if (fin_meta.status == CAL_COMPLETE) begin
      if (fin_meta.zero_res)                res_c = '0;
      else if (res_c > 10'(fin_meta.cap))   res_c = 10'(fin_meta.cap);
    end
  end

  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= dq_vld_r[QBITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {2'b0, fin_meta.status, fin_meta.err, fin_meta.clamped, res_c};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the dissolved oxygen converter: directed and random beats.
module tb;
  import doc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] probe_voltage;
    logic signed [14:0] water_temp;
  } sample_t;

  typedef struct packed {
    logic [9:0] oxygen_tenths;
    logic       temp_clamped;
    logic       span_error;
    logic [1:0] calib_status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dissolved_oxygen_converter uut (.*);

  always #6 clk = ~clk;

  // Calibration copy held by the predictor
  logic [15:0] cal_zero, cal_vlow, cal_vhigh;
  logic [11:0] cal_tlow, cal_thigh;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_off = 0;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  logic in_tready_seen = 1'b0;

  function automatic reading_t predict_reading(sample_t s);
    reading_t r;
    longint v, t, sat, z, vl, vh, tl, th, d, span, num, den, q, cap, res, idx;
    v = s.probe_voltage;
    t = s.water_temp;
    r = '0;
    if (cal_zero == 0) r.calib_status = CAL_NONE;
    else if (cal_vlow != 0 && cal_vhigh != 0) r.calib_status = CAL_COMPLETE;
    else if (cal_vlow != 0 || cal_vhigh != 0) r.calib_status = CAL_PARTIAL;
    else r.calib_status = CAL_NONE;
    if (t < 1500) begin
      t = 1500;
      r.temp_clamped = 1'b1;
    end else if (t > 4000) begin
      t = 4000;
      r.temp_clamped = 1'b1;
    end
    idx = (t - 1500) / 100;
    if (idx > SAT_ROWS - 1) idx = SAT_ROWS - 1;
    sat = SAT_TABLE[idx];
    res = 0;
    if (r.calib_status == CAL_COMPLETE) begin
      z = cal_zero; vl = cal_vlow; vh = cal_vhigh; tl = cal_tlow; th = cal_thigh;
      if (t <= tl) begin
        d = 1; span = vl - z;
      end else if (t >= th) begin
        d = 1; span = vh - z;
      end else begin
        d = th - tl;
        span = vl * d + (t - tl) * (vh - vl) - z * d;
      end
      if (span < 500 * d) r.span_error = 1'b1;
      else if (v > z) begin
        num = sat * (v - z) * d;
        den = span * 10;
        q = (2 * num + den) / (2 * den);
        cap = (sat + 5) / 10;
        res = (q > cap) ? cap : q;
      end
    end else begin
      res = (sat * v + 50000) / 100000;
    end
    r.oxygen_tenths = (res > 1023) ? 10'd1023 : res[9:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ZERO_VOLTAGE:     cal_zero = val;
      REG_SAT_VOLTAGE_LOW:  cal_vlow = val;
      REG_SAT_VOLTAGE_HIGH: cal_vhigh = val;
      REG_SAT_TEMP_LOW:     cal_tlow = val[11:0];
      REG_SAT_TEMP_HIGH:    cal_thigh = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cal(int z, int vl, int vh, int tl, int th);
    write_reg(REG_ZERO_VOLTAGE, 16'(z));
    write_reg(REG_SAT_VOLTAGE_LOW, 16'(vl));
    write_reg(REG_SAT_VOLTAGE_HIGH, 16'(vh));
    write_reg(REG_SAT_TEMP_LOW, 16'(tl));
    write_reg(REG_SAT_TEMP_HIGH, 16'(th));
  endtask

  // Wait until every beat is out and the pipeline is empty
  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 9);
    s.probe_voltage = (k < 7) ? 16'($urandom_range(0, 50000)) : 16'($urandom);
    k = $urandom_range(0, 9);
    if (k < 7) s.water_temp = 15'($urandom_range(1400, 4100));
    else s.water_temp = 15'($urandom);
    return s;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_samples.push_back(random_sample());
  endtask

  task automatic queue_sample(int v, int t);
    sample_t s;
    s.probe_voltage = 16'(v);
    s.water_temp = 15'(t);
    pending_samples.push_back(s);
  endtask

  // Driver: bursts with random gaps, beats change on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_seen) begin
        // beat went at the last rising edge; choose what follows
      end
      if (!in_tvalid || in_tready_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_tdata <= {1'b0, pending_samples[0].water_temp, pending_samples[0].probe_voltage};
          expected_readings.push_back(predict_reading(pending_samples[0]));
          void'(pending_samples.pop_front());
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 4);
            gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Acceptance seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) in_tready_seen <= in_tvalid && in_tready;

  // Receiver stall pattern, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_off <= 200;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    reading_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[9:0], out_tdata[10], out_tdata[11], out_tdata[13:12]};
      if (expected_readings.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        errors = errors + 1;
      end else begin
        want = expected_readings.pop_front();
        if (got.oxygen_tenths !== want.oxygen_tenths) begin
          $error("oxygen_tenths exp %0d got %0d", want.oxygen_tenths, got.oxygen_tenths);
          errors = errors + 1;
        end
        if (got.temp_clamped !== want.temp_clamped) begin
          $error("temp_clamped exp %0d got %0d", want.temp_clamped, got.temp_clamped);
          errors = errors + 1;
        end
        if (got.span_error !== want.span_error) begin
          $error("span_error exp %0d got %0d", want.span_error, got.span_error);
          errors = errors + 1;
        end
        if (got.calib_status !== want.calib_status) begin
          $error("calib_status exp %0d got %0d", want.calib_status, got.calib_status);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cal_zero = 0; cal_vlow = 0; cal_vhigh = 0; cal_tlow = 2500; cal_thigh = 2500;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Uncalibrated: extremes of voltage and temperature
    queue_sample(0, 1500);
    queue_sample(65535, -16384);
    queue_sample(50000, 16383);
    queue_sample(12345, 4000);
    queue_sample(30000, 4001);
    queue_sample(30000, 1499);
    queue_sample(40000, 3999);
    queue_sample(21845, 10922);
    queue_sample(43690, -10923);
    drain();

    // Partial calibration, only the low saturation voltage
    write_cal(2000, 30000, 0, 2000, 3000);
    queue_sample(25000, 2500);
    queue_sample(65535, 1500);
    drain();

    // Complete: interpolate, below zero, above saturation, span too small
    write_cal(2000, 30000, 34000, 2000, 3000);
    queue_sample(2000, 2500);
    queue_sample(1000, 2500);
    queue_sample(16000, 2500);
    queue_sample(65535, 2999);
    queue_sample(20000, 1800);
    queue_sample(20000, 3500);
    drain();
    write_cal(2000, 2400, 2600, 3000, 2000);
    queue_sample(10000, 2500);
    queue_sample(10000, 3500);
    queue_sample(10000, 1500);
    drain();

    // Random phases across calibrations, extremes among them
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_cal(0, 0, 0, 0, 0);
        1: write_cal(65535, 65535, 65535, 4095, 4095);
        2: write_cal(50000, 50000, 50000, 4000, 4000);
        3: write_cal(1, 501, 65535, 0, 4095);
        4: write_cal(0, 30000, 30000, 1500, 4000);
        default: write_cal($urandom_range(1, 8000), $urandom_range(0, 50000),
                           $urandom_range(0, 50000), $urandom_range(1200, 4095),
                           $urandom_range(1200, 4095));
      endcase
      queue_random(ph == 5 ? 160 : 50);
      if (ph == 5) begin
        // Long receiver hold-off while beats keep coming
        hold_req = 1'b1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
